// ===== sv/ttd_pkg.sv =====
// ttd_pkg: types and constants shared by the typed task dispatcher modules
// holds the item structs, the stored task format, status codes and fsm states
// no dependencies
package ttd_pkg;

    localparam int CYCLES_WIDTH = 4;
    localparam int TYPE_WIDTH   = 2;
    localparam int NUM_UNITS    = 3;

    localparam logic [TYPE_WIDTH-1:0] TYPE_INVALID = 2'd3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        FN_SUBMIT = 1'b0,
        FN_TICK   = 1'b1
    } t_func;

    // input item
    typedef struct packed {
        t_func                   func;
        logic [TYPE_WIDTH-1:0]   task_type;
        logic [CYCLES_WIDTH-1:0] task_cycles;
    } t_in_item;

    // result item
    typedef struct packed {
        t_status                 status;
        logic [CYCLES_WIDTH-1:0] remain_unit0;
        logic [CYCLES_WIDTH-1:0] remain_unit1;
        logic [CYCLES_WIDTH-1:0] remain_unit2;
        logic [1:0]              queue_fill;
        logic [4:0]              stack_fill;
        logic [4:0]              pending_fill;
        logic                    all_idle;
    } t_out_item;

    // task as held in the pending fifo, hold queue and spill stack
    typedef struct packed {
        logic [TYPE_WIDTH-1:0]   ttype;
        logic [CYCLES_WIDTH-1:0] cycles;
    } t_task;

    localparam int TASK_WIDTH = $bits(t_task);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_FILL_WR,
        S_DISP,
        S_RETRY,
        S_RETRY_WR,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic submit;
        logic fill_rd;
        logic fill_wr;
        logic dispatch;
        logic retry_rd;
        logic retry_wr;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  can_fill;
        logic  retry_ok;
        logic  out_free;
    } t_stat;

endpackage

// ===== sv/typed_task_dispatcher.sv =====
// typed_task_dispatcher: one item at a time; ready again in the cycle after a result loads
// submit item: after acceptance it passes the decode state, then the result loads in the done state
// tick item: after acceptance it passes decode, then a fill loop moving F tasks from the
// pending fifo (0..HOLD_DEPTH, one ram read and one write each), dispatch, stack retry, result load
// a result waiting at the output holds the block in its final state until taken
// synchronous active-low reset clears counts, pointers, unit counters and the fsm; stores are not cleared
module typed_task_dispatcher
    import ttd_pkg::*;
#(
    parameter int HOLD_DEPTH    = 3,
    parameter int PENDING_DEPTH = 16,
    parameter int SPILL_DEPTH   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    ttd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_ready),
        .o_cmd      (w_cmd)
    );

    // stores, counters and output register
    ttd_datapath #(
        .HOLD_DEPTH    (HOLD_DEPTH),
        .PENDING_DEPTH (PENDING_DEPTH),
        .SPILL_DEPTH   (SPILL_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_valid),
        .o_out_data  (o_data)
    );

    // one item in flight: ready drops after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while another is in flight");

    // every pending read is followed by the hold queue write
    a_fill_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fill_rd |=> w_cmd.fill_wr)
        else $error("pending read not followed by hold write");

    // a loaded result is presented
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_valid)
        else $error("loaded result not presented");

    // idle flag agrees with the fill and unit fields
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.all_idle) |->
        (o_data.queue_fill == '0 && o_data.stack_fill == '0 && o_data.pending_fill == '0 &&
         o_data.remain_unit0 == '0 && o_data.remain_unit1 == '0 &&
         o_data.remain_unit2 == '0))
        else $error("idle flag with non-empty store or busy unit");

endmodule

// ===== sv/ttd_ram.sv =====
// ttd_ram: generic single write port ram with registered read
// no package dependency
module ttd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ttd_ctrl.sv =====
// ttd_ctrl: sequencing state machine of the typed task dispatcher
// depends on ttd_pkg for the state, command and status types
module ttd_ctrl
    import ttd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.func == FN_SUBMIT) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_stat.can_fill) begin
                    n_state = S_FILL_WR;
                end else begin
                    n_state = S_DISP;
                end
            end
            S_FILL_WR:  n_state = S_FILL;
            S_DISP:     n_state = S_RETRY;
            S_RETRY: begin
                if (i_stat.retry_ok) begin
                    n_state = S_RETRY_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RETRY_WR: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.submit = (i_stat.func == FN_SUBMIT);
            end
            S_FILL: begin
                o_cmd.fill_rd = i_stat.can_fill;
            end
            S_FILL_WR: begin
                o_cmd.fill_wr = 1'b1;
            end
            S_DISP: begin
                o_cmd.dispatch = 1'b1;
            end
            S_RETRY: begin
                o_cmd.retry_rd = i_stat.retry_ok;
            end
            S_RETRY_WR: begin
                o_cmd.retry_wr = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/ttd_datapath.sv =====
// ttd_datapath: pending fifo, hold queue, spill stack, unit counters, output register
// depends on ttd_pkg and on ttd_ram for the pending fifo and spill stack storage
module ttd_datapath
    import ttd_pkg::*;
#(
    parameter int HOLD_DEPTH    = 3,
    parameter int PENDING_DEPTH = 16,
    parameter int SPILL_DEPTH   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_data,
    input  t_cmd      i_cmd,
    input  logic      i_out_ready,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int PAW = $clog2(PENDING_DEPTH);
    localparam int PNW = $clog2(PENDING_DEPTH + 1);
    localparam int SAW = $clog2(SPILL_DEPTH);
    localparam int SNW = $clog2(SPILL_DEPTH + 1);
    localparam int HNW = $clog2(HOLD_DEPTH + 1);

    // captured item and status
    t_in_item r_in;
    t_status  r_status;

    // pending fifo control
    logic [PAW-1:0] r_rd_ptr;
    logic [PAW-1:0] r_wr_ptr;
    logic [PNW-1:0] r_pend_num;
    logic           w_pend_full;
    logic           w_pend_we;
    logic [TASK_WIDTH-1:0] w_pend_wdata;
    logic [TASK_WIDTH-1:0] w_pend_rdata;

    // hold queue
    t_task          r_hold [HOLD_DEPTH];
    logic [HNW-1:0] r_hold_num;
    logic           w_hold_any;

    // spill stack
    logic [SNW-1:0] r_spill_num;
    logic [SNW-1:0] w_spill_top;
    logic           w_spill_full;
    logic [TASK_WIDTH-1:0] w_spill_rdata;

    // units
    logic [CYCLES_WIDTH-1:0] r_left [NUM_UNITS];
    logic [CYCLES_WIDTH-1:0] w_cur  [NUM_UNITS];
    logic [CYCLES_WIDTH-1:0] w_dec  [NUM_UNITS];
    logic [NUM_UNITS-1:0]    w_load;
    logic [NUM_UNITS-1:0]    w_top_free;

    t_task   w_head;
    t_task   w_top;
    logic    w_head_bad;
    logic    w_push;
    logic    w_retry_hit;
    t_status w_disp_status;
    logic    w_idle;

    logic [HNW+1:0] w_hold_ext;
    logic [SNW+4:0] w_spill_ext;
    logic [PNW+4:0] w_pend_ext;

    logic      r_out_valid;
    t_out_item r_out;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_data;
        end
    end

    assign w_pend_full  = (r_pend_num == PNW'(PENDING_DEPTH));
    assign w_pend_we    = i_cmd.submit && !w_pend_full;
    assign w_pend_wdata = {r_in.task_type, r_in.task_cycles};

    ttd_ram #(
        .WIDTH (TASK_WIDTH),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (w_pend_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (w_pend_wdata),
        .i_re    (i_cmd.fill_rd),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_pend_rdata)
    );

    // pending fifo pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_pend_num <= '0;
        end else begin
            if (w_pend_we) begin
                r_wr_ptr   <= (r_wr_ptr == PAW'(PENDING_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                r_pend_num <= r_pend_num + 1'b1;
            end else if (i_cmd.fill_wr) begin
                r_rd_ptr   <= (r_rd_ptr == PAW'(PENDING_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                r_pend_num <= r_pend_num - 1'b1;
            end
        end
    end

    // head of the hold queue against the units
    assign w_head     = r_hold[0];
    assign w_hold_any = (r_hold_num != '0);
    assign w_head_bad = (w_head.ttype == TYPE_INVALID);

    always_comb begin
        for (int k = 0; k < NUM_UNITS; k++) begin
            w_load[k] = w_hold_any && (w_head.ttype == TYPE_WIDTH'(k)) &&
                        (r_left[k] == '0);
            w_cur[k]  = w_load[k] ? w_head.cycles : r_left[k];
            w_dec[k]  = (w_cur[k] != '0) ? w_cur[k] - 1'b1 : w_cur[k];
        end
    end

    assign w_spill_full = (r_spill_num == SNW'(SPILL_DEPTH));
    assign w_push       = w_hold_any && !w_head_bad && !(|w_load) && !w_spill_full;

    always_comb begin
        if (!w_hold_any) begin
            w_disp_status = ST_OK;
        end else if (w_head_bad) begin
            w_disp_status = ST_INVALID;
        end else if ((|w_load) || !w_spill_full) begin
            w_disp_status = ST_OK;
        end else begin
            w_disp_status = ST_OVERFLOW;
        end
    end

    // hold queue slots: fill at the tail, shift towards the head on dispatch
    for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_hold
        if (i < HOLD_DEPTH - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_cmd.fill_wr && r_hold_num == HNW'(i)) begin
                    r_hold[i] <= t_task'(w_pend_rdata);
                end else if (i_cmd.dispatch && w_hold_any) begin
                    r_hold[i] <= r_hold[i+1];
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_cmd.fill_wr && r_hold_num == HNW'(i)) begin
                    r_hold[i] <= t_task'(w_pend_rdata);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_num <= '0;
        end else if (i_cmd.fill_wr) begin
            r_hold_num <= r_hold_num + 1'b1;
        end else if (i_cmd.dispatch && w_hold_any) begin
            r_hold_num <= r_hold_num - 1'b1;
        end
    end

    // spill stack storage, push at the count, read the top
    assign w_spill_top = r_spill_num - 1'b1;

    ttd_ram #(
        .WIDTH (TASK_WIDTH),
        .DEPTH (SPILL_DEPTH)
    ) u_spill_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.dispatch && w_push),
        .i_waddr (r_spill_num[SAW-1:0]),
        .i_wdata (w_head),
        .i_re    (i_cmd.retry_rd),
        .i_raddr (w_spill_top[SAW-1:0]),
        .o_rdata (w_spill_rdata)
    );

    // stack top against the units
    assign w_top = t_task'(w_spill_rdata);

    always_comb begin
        for (int k = 0; k < NUM_UNITS; k++) begin
            w_top_free[k] = (w_top.ttype == TYPE_WIDTH'(k)) && (r_left[k] == '0);
        end
    end

    assign w_retry_hit = |w_top_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spill_num <= '0;
        end else if (i_cmd.dispatch && w_push) begin
            r_spill_num <= r_spill_num + 1'b1;
        end else if (i_cmd.retry_wr && w_retry_hit) begin
            r_spill_num <= r_spill_num - 1'b1;
        end
    end

    // unit counters: load and count down on dispatch, load only on stack retry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_UNITS; k++) begin
                r_left[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_UNITS; k++) begin
                if (i_cmd.dispatch) begin
                    r_left[k] <= w_dec[k];
                end else if (i_cmd.retry_wr && w_top_free[k]) begin
                    r_left[k] <= w_top.cycles;
                end
            end
        end
    end

    // item status
    always_ff @(posedge i_clk) begin
        if (i_cmd.submit) begin
            r_status <= w_pend_full ? ST_REJECT : ST_OK;
        end else if (i_cmd.dispatch) begin
            r_status <= w_disp_status;
        end
    end

    // result fields
    assign w_idle = (r_hold_num == '0) && (r_pend_num == '0) && (r_spill_num == '0) &&
                    (r_left[0] == '0) && (r_left[1] == '0) && (r_left[2] == '0);

    assign w_hold_ext  = {2'b00, r_hold_num};
    assign w_spill_ext = {5'b00000, r_spill_num};
    assign w_pend_ext  = {5'b00000, r_pend_num};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status       <= r_status;
            r_out.remain_unit0 <= r_left[0];
            r_out.remain_unit1 <= r_left[1];
            r_out.remain_unit2 <= r_left[2];
            r_out.queue_fill   <= w_hold_ext[1:0];
            r_out.stack_fill   <= w_spill_ext[4:0];
            r_out.pending_fill <= w_pend_ext[4:0];
            r_out.all_idle     <= w_idle;
        end
    end

    // status back to the controller
    assign o_stat.func     = r_in.func;
    assign o_stat.can_fill = (r_hold_num < HNW'(HOLD_DEPTH)) && (r_pend_num != '0);
    assign o_stat.retry_ok = (r_hold_num == '0) && (r_pend_num == '0) &&
                             (r_spill_num != '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
